// ===== hdl/tpba_pkg.sv =====
// shared types, constants and the divide-by-three helper for the three tap box average
package tpba_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned SumWidth  = 10;
   localparam int unsigned ProdWidth = 19;
   // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
   localparam logic [ProdWidth-1:0] Recip3    = 19'd683;
   localparam int unsigned          Recip3Sh  = 11;

   typedef logic [ChanWidth-1:0] chan_type;

   typedef struct packed {
      chan_type c2;
      chan_type c1;
      chan_type c0;
   } pixel_type;

   localparam pixel_type PixelZero = '{c2: '0, c1: '0, c0: '0};

   // one queued job: the incoming pixel, the two held pixels, how many were held and the last flag
   typedef struct packed {
      pixel_type   older;
      pixel_type   newer;
      pixel_type   px;
      logic [1:0]  seen;
      logic        last;
   } job_type;

   localparam logic [1:0] SeenNone = 2'd0;
   localparam logic [1:0] SeenOne  = 2'd1;
   localparam logic [1:0] SeenTwo  = 2'd2;

   // which window the back end emits next for the job at the queue head
   typedef enum logic [2:0] {
      KIND_FULL   = 3'b001,
      KIND_PAIR   = 3'b010,
      KIND_SINGLE = 3'b100
   } kind_type;

   function automatic chan_type avg3(input chan_type a, input chan_type b, input chan_type c);
      logic [SumWidth-1:0]  sum;
      logic [ProdWidth-1:0] prod;
      sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
      prod = {{(ProdWidth-SumWidth){1'b0}}, sum} * Recip3;
      return prod[Recip3Sh +: ChanWidth];
   endfunction

endpackage

// ===== hdl/tpba_queue.sv =====
// small register fifo between the front and back parts
module tpba_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);
   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(DEPTH);
   localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(DEPTH - 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == DepthCnt);
   assign head_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
endmodule

// ===== hdl/tpba_front.sv =====
// front part: takes pixels, keeps the two-pixel history and queues result-producing jobs
module tpba_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpba_pkg::chan_type req_chan0_in,
   input  tpba_pkg::chan_type req_chan1_in,
   input  tpba_pkg::chan_type req_chan2_in,
   input  logic               req_last_pixel,
   input  logic               queue_full,
   output logic               job_push,
   output tpba_pkg::job_type  job
);
   import tpba_pkg::*;

   pixel_type  hist0_ff, hist0_in;
   pixel_type  hist1_ff, hist1_in;
   logic [1:0] seen_ff, seen_in;
   logic       accept;
   pixel_type  px;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign px        = '{c2: req_chan2_in, c1: req_chan1_in, c0: req_chan0_in};

   // only pixels that cause a result go to the back part
   assign job_push = accept && (req_last_pixel || (seen_ff == SeenTwo));
   assign job      = '{older: hist1_ff, newer: hist0_ff, px: px,
                       seen: seen_ff, last: req_last_pixel};

   always_comb begin
      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (req_last_pixel) begin
            hist0_in = PixelZero;
            hist1_in = PixelZero;
            seen_in  = SeenNone;
         end else begin
            hist1_in = hist0_ff;
            hist0_in = px;
            seen_in  = (seen_ff == SeenTwo) ? SeenTwo : seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= PixelZero;
         hist1_ff <= PixelZero;
         seen_ff  <= SeenNone;
      end else begin
         hist0_ff <= hist0_in;
         hist1_ff <= hist1_in;
         seen_ff  <= seen_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_pixel |=> seen_ff == SeenNone) else $error("history not cleared");
endmodule

// ===== hdl/tpba_back.sv =====
// back part: expands each queued job into one to three averaged pixels
module tpba_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  tpba_pkg::job_type  head,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tpba_pkg::chan_type rsp_chan0_out,
   output tpba_pkg::chan_type rsp_chan1_out,
   output tpba_pkg::chan_type rsp_chan2_out,
   output logic               rsp_end_of_image
);
   import tpba_pkg::*;

   logic      mid_ff, mid_in;
   kind_type  kind_ff, kind_in;
   kind_type  start_kind, cur_kind, next_kind;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type out_px_ff, out_px_in;
   logic      eoi_ff, eoi_in;
   logic      slot_free, fire, job_done;
   pixel_type opa, opb, opc;

   always_comb begin
      priority if (head.seen == SeenTwo) begin
         start_kind = KIND_FULL;
      end else if (head.seen == SeenOne) begin
         start_kind = KIND_PAIR;
      end else begin
         start_kind = KIND_SINGLE;
      end
   end

   assign cur_kind  = mid_ff ? kind_ff : start_kind;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fire      = !queue_empty && slot_free;

   always_comb begin
      unique case (cur_kind)
         KIND_FULL: begin
            opa = head.older; opb = head.newer; opc = head.px;
            job_done  = !head.last;
            next_kind = KIND_PAIR;
         end
         KIND_PAIR: begin
            opa = head.newer; opb = head.px; opc = PixelZero;
            job_done  = 1'b0;
            next_kind = KIND_SINGLE;
         end
         KIND_SINGLE: begin
            opa = head.px; opb = PixelZero; opc = PixelZero;
            job_done  = 1'b1;
            next_kind = KIND_SINGLE;
         end
         default: begin
            opa = PixelZero; opb = PixelZero; opc = PixelZero;
            job_done  = 1'b1;
            next_kind = KIND_SINGLE;
         end
      endcase
   end

   assign queue_pop = fire && job_done;

   always_comb begin
      mid_in       = mid_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_px_in    = out_px_ff;
      eoi_in       = eoi_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         out_px_in    = '{c2: avg3(opa.c2, opb.c2, opc.c2),
                          c1: avg3(opa.c1, opb.c1, opc.c1),
                          c0: avg3(opa.c0, opb.c0, opc.c0)};
         eoi_in       = (cur_kind == KIND_SINGLE);
         mid_in       = !job_done;
         kind_in      = next_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         kind_ff      <= KIND_SINGLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_ff       <= mid_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_px_ff <= out_px_in;
      eoi_ff    <= eoi_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chan0_out    = out_px_ff.c0;
   assign rsp_chan1_out    = out_px_ff.c1;
   assign rsp_chan2_out    = out_px_ff.c2;
   assign rsp_end_of_image = eoi_ff;

   a_mid_has_job: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> !queue_empty) else $error("job expansion without queued job");
   a_mid_kind: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> (kind_ff == KIND_PAIR || kind_ff == KIND_SINGLE))
      else $error("bad continuation window");
endmodule

// ===== hdl/three_tap_pixel_box_average_core.sv =====
// top level of the three tap pixel box average: front, job queue and back
// usage:
//   req_ channel carries one 24-bit pixel (three 8-bit channels) per transfer,
//   in scan order, with req_last_pixel high on the final pixel of an image.
//   rsp_ channel carries averaged pixels; each channel of output j is
//   floor((p[j] + p[j+1] + p[j+2]) / 3), with missing terms past the image end
//   taken as zero. rsp_end_of_image marks the very last output of an image.
// path and throughput:
//   the result for pixel n-2 leaves after pixel n is taken, through the
//   queue register, then the output register. one pixel per cycle in
//   steady state while rsp_ready is high; the final pixel of an image
//   expands into up to three results, one per cycle while rsp_ready is high.
//   the back end's one-result-per-cycle window unit sets this rate.
// reset:
//   synchronous, active high; clears history, queue and output valid.
// stalls:
//   when rsp_ready is low the output register holds; the queue absorbs up to
//   QUEUE_DEPTH jobs before req_ready drops.
module three_tap_pixel_box_average_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpba_pkg::chan_type req_chan0_in,
   input  tpba_pkg::chan_type req_chan1_in,
   input  tpba_pkg::chan_type req_chan2_in,
   input  logic               req_last_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tpba_pkg::chan_type rsp_chan0_out,
   output tpba_pkg::chan_type rsp_chan1_out,
   output tpba_pkg::chan_type rsp_chan2_out,
   output logic               rsp_end_of_image
);
   import tpba_pkg::*;

   // front to queue
   logic    job_push;
   job_type job_new;
   // queue to back
   logic    queue_full, queue_empty, queue_pop;
   job_type job_head;
   logic [$bits(job_type)-1:0] head_bits;

   tpba_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan0_in   (req_chan0_in),
      .req_chan1_in   (req_chan1_in),
      .req_chan2_in   (req_chan2_in),
      .req_last_pixel (req_last_pixel),
      .queue_full     (queue_full),
      .job_push       (job_push),
      .job            (job_new)
   );

   // jobs waiting for expansion
   tpba_queue #(
      .WIDTH ($bits(job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_new),
      .pop       (queue_pop),
      .head_data (head_bits),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   assign job_head = job_type'(head_bits);

   tpba_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .head             (job_head),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chan0_out    (rsp_chan0_out),
      .rsp_chan1_out    (rsp_chan1_out),
      .rsp_chan2_out    (rsp_chan2_out),
      .rsp_end_of_image (rsp_end_of_image)
   );

   // a queued job always yields a result in the following cycle once the output is free
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !queue_empty && (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("queued job not drained");
endmodule
